>>> sv/rssi_tagged_channel_ring_defines.svh
// assertion macros for the tag ring
`ifndef RSSI_TAGGED_CHANNEL_RING_DEFINES_SVH
`define RSSI_TAGGED_CHANNEL_RING_DEFINES_SVH

// same-cycle implication
`define RTCR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RTCR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/rtcr_pkg.sv
`default_nettype none

package rtcr_pkg;

  localparam int CHANNEL_W = 6;
  localparam int RSSI_W = 8;
  localparam int DISCARD_W = 16;
  localparam int RING_DEPTH_DEF = 64;

  localparam logic [CHANNEL_W-1:0] FALLBACK_CHANNEL = CHANNEL_W'(37);
  localparam logic [DISCARD_W-1:0] DISCARD_MAX = '1;

  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_POP = 1'b1;

  typedef struct packed {
    logic [CHANNEL_W-1:0] channel;
    logic [RSSI_W-1:0] rssi;
  } tag_t;

  localparam int TAG_W = $bits(tag_t);

endpackage

`default_nettype wire

>>> sv/rtcr_chan_if.sv
`default_nettype none

interface rtcr_req_if;
  logic valid;
  logic ready;
  logic req_type;
  logic [rtcr_pkg::CHANNEL_W-1:0] rx_channel;
  logic signed [rtcr_pkg::RSSI_W-1:0] rx_rssi;
  logic kept;
  logic signed [rtcr_pkg::RSSI_W-1:0] expected_rssi;

  modport source (output valid, req_type, rx_channel, rx_rssi, kept, expected_rssi,
                  input ready);
  modport sink (input valid, req_type, rx_channel, rx_rssi, kept, expected_rssi,
                output ready);
endinterface

interface rtcr_rsp_if;
  logic valid;
  logic ready;
  logic [rtcr_pkg::CHANNEL_W-1:0] channel_out;
  logic matched;
  logic [rtcr_pkg::DISCARD_W-1:0] discard_count;

  modport source (output valid, channel_out, matched, discard_count, input ready);
  modport sink (input valid, channel_out, matched, discard_count, output ready);
endinterface

`default_nettype wire

>>> sv/rtcr_ram.sv
`default_nettype none

module rtcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/rssi_tagged_channel_ring.sv
// channel | role | payload
// req     | sink   | req_type, rx_channel, rx_rssi, kept, expected_rssi
// rsp     | source | channel_out, matched, discard_count (one per pop item)
//
// a record item leaves the block idle and ready for the next item; a pop item reads the
// ring entries one at a time, examining 1 to RING_DEPTH of them, or skips the scan when
// nothing was recorded yet; no new item is taken until the pop result is loaded.
// after reset a clearing pass writes zero to every entry before the first item is taken.
// the result register holds a finished pop result while records and new pops go on;
// a pop waits in its last state (FIN) only while an earlier result is still untaken.
`default_nettype none

`include "rssi_tagged_channel_ring_defines.svh"

module rssi_tagged_channel_ring #(
  parameter int RING_DEPTH = rtcr_pkg::RING_DEPTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  rtcr_req_if.sink req,
  rtcr_rsp_if.source rsp
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RING_DEPTH);

  typedef enum logic [1:0] {
    CLEAR,
    IDLE,
    SCAN,
    FIN
  } state_t;

  state_t state;

  logic [PTR_W-1:0] write_pointer;
  logic [PTR_W-1:0] read_pointer;
  logic seen_once;
  logic [rtcr_pkg::DISCARD_W-1:0] discards;
  logic [PTR_W-1:0] clr_ptr;

  logic [rtcr_pkg::RSSI_W-1:0] want;
  logic [PTR_W-1:0] issue_ptr;
  logic [CNT_W-1:0] issue_cnt;
  logic cmp_valid;
  logic [PTR_W-1:0] cmp_ptr;
  logic [PTR_W-1:0] exam_cnt;

  logic [rtcr_pkg::CHANNEL_W-1:0] res_channel;
  logic res_matched;
  logic [rtcr_pkg::DISCARD_W-1:0] res_discard;

  logic out_valid;
  logic [rtcr_pkg::CHANNEL_W-1:0] out_channel;
  logic out_matched;
  logic [rtcr_pkg::DISCARD_W-1:0] out_discard;

  logic req_fire;
  logic pop_fire;
  logic keep_fire;
  logic ram_we;
  logic [PTR_W-1:0] ram_waddr;
  rtcr_pkg::tag_t ram_wdata;
  logic ram_re;
  rtcr_pkg::tag_t rd_tag;
  logic hit;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

  assign req.ready = (state == IDLE);
  assign req_fire = req.valid && req.ready;
  assign pop_fire = req_fire && (req.req_type == rtcr_pkg::REQ_POP);
  assign keep_fire = req_fire && (req.req_type == rtcr_pkg::REQ_RECORD) && req.kept;

  assign rsp.valid = out_valid;
  assign rsp.channel_out = out_channel;
  assign rsp.matched = out_matched;
  assign rsp.discard_count = out_discard;

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = write_pointer;
    ram_wdata.channel = req.rx_channel;
    ram_wdata.rssi = $unsigned(req.rx_rssi);
    if (state == CLEAR) begin
      ram_we = 1'b1;
      ram_waddr = clr_ptr;
      ram_wdata = '0;
    end else if (keep_fire) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re = (state == SCAN) && (issue_cnt != FULL_CNT);
  assign hit = cmp_valid && (rd_tag.rssi == want);

  rtcr_ram #(
    .WIDTH(rtcr_pkg::TAG_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re(ram_re),
    .raddr(issue_ptr),
    .rdata(rd_tag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
      clr_ptr <= '0;
      write_pointer <= '0;
      read_pointer <= '0;
      seen_once <= 1'b0;
      discards <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // the last state loads the result register itself
      if (out_valid && rsp.ready && state != FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        CLEAR: begin
          clr_ptr <= next_ptr(clr_ptr);
          if (clr_ptr == LAST_PTR) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (req_fire) begin
            if (req.req_type == rtcr_pkg::REQ_RECORD) begin
              seen_once <= 1'b1;
              if (req.kept) begin
                write_pointer <= next_ptr(write_pointer);
              end else if (discards != rtcr_pkg::DISCARD_MAX) begin
                discards <= discards + rtcr_pkg::DISCARD_W'(1);
              end
            end else begin
              res_discard <= discards;
              discards <= '0;
              want <= $unsigned(req.expected_rssi);
              issue_ptr <= read_pointer;
              issue_cnt <= '0;
              exam_cnt <= '0;
              cmp_valid <= 1'b0;
              res_channel <= rtcr_pkg::FALLBACK_CHANNEL;
              res_matched <= 1'b0;
              state <= seen_once ? SCAN : FIN;
            end
          end
        end
        SCAN: begin
          if (issue_cnt != FULL_CNT) begin
            issue_ptr <= next_ptr(issue_ptr);
            issue_cnt <= issue_cnt + CNT_W'(1);
            cmp_ptr <= issue_ptr;
            cmp_valid <= 1'b1;
          end else begin
            cmp_valid <= 1'b0;
          end
          if (cmp_valid) begin
            if (hit) begin
              res_channel <= rd_tag.channel;
              res_matched <= 1'b1;
              read_pointer <= next_ptr(cmp_ptr);
              state <= FIN;
            end else if (exam_cnt == LAST_PTR) begin
              state <= FIN;
            end else begin
              exam_cnt <= exam_cnt + PTR_W'(1);
            end
          end
        end
        FIN: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_channel <= res_channel;
            out_matched <= res_matched;
            out_discard <= res_discard;
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `RTCR_ASSERT_IMP(a_no_item_in_clear, state == CLEAR, !req.ready, "item taken during clear")
  `RTCR_ASSERT_NXT(a_pop_clears_discards, pop_fire, discards == '0, "discards not cleared")
  `RTCR_ASSERT_NXT(a_kept_advances_wp, keep_fire, write_pointer == next_ptr($past(write_pointer)), "wp stuck")
  `RTCR_ASSERT_IMP(a_scan_no_write, state == SCAN, !ram_we, "ring written during scan")

endmodule

`default_nettype wire

>>> sim/testbench.sv
`default_nettype none

module testbench;

  localparam int DEPTH = rtcr_pkg::RING_DEPTH_DEF;
  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    logic req_type;
    logic [rtcr_pkg::CHANNEL_W-1:0] rx_channel;
    logic signed [rtcr_pkg::RSSI_W-1:0] rx_rssi;
    logic kept;
    logic signed [rtcr_pkg::RSSI_W-1:0] expected_rssi;
  } req_item_t;

  typedef struct packed {
    logic [rtcr_pkg::CHANNEL_W-1:0] channel;
    logic matched;
    logic [rtcr_pkg::DISCARD_W-1:0] discards;
  } pop_result_t;

  logic clk;
  logic rst;

  rtcr_req_if req_ch ();
  rtcr_rsp_if rsp_ch ();

  rssi_tagged_channel_ring #(
    .RING_DEPTH(DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // predicted ring contents
  rtcr_pkg::tag_t tag_store [DEPTH];
  int unsigned wr_slot;
  int unsigned rd_slot;
  bit any_record;
  logic [rtcr_pkg::DISCARD_W-1:0] drop_count;
  pop_result_t pop_results_due [$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_off;
  int mismatches;
  int idle_run;
  logic signed [rtcr_pkg::RSSI_W-1:0] last_rssi;

  function automatic void clear_ring_model();
    for (int i = 0; i < DEPTH; i++) begin
      tag_store[i] = '0;
    end
    wr_slot = 0;
    rd_slot = 0;
    any_record = 1'b0;
    drop_count = '0;
  endfunction

  function automatic void apply_to_ring_model(input req_item_t it);
    pop_result_t res;
    rtcr_pkg::tag_t t;
    if (it.req_type == rtcr_pkg::REQ_RECORD) begin
      any_record = 1'b1;
      if (it.kept) begin
        t.channel = it.rx_channel;
        t.rssi = it.rx_rssi;
        tag_store[wr_slot] = t;
        wr_slot = (wr_slot + 1) % DEPTH;
      end else if (drop_count != rtcr_pkg::DISCARD_MAX) begin
        drop_count = drop_count + 1'b1;
      end
    end else begin
      res.channel = rtcr_pkg::FALLBACK_CHANNEL;
      res.matched = 1'b0;
      res.discards = drop_count;
      drop_count = '0;
      if (any_record) begin
        for (int n = 0; n < DEPTH; n++) begin
          t = tag_store[rd_slot];
          rd_slot = (rd_slot + 1) % DEPTH;
          if (t.rssi == it.expected_rssi) begin
            res.channel = t.channel;
            res.matched = 1'b1;
            break;
          end
        end
      end
      pop_results_due.push_back(res);
    end
  endfunction

  function automatic req_item_t make_record(input int ch, input int rssi, input bit keep);
    req_item_t it;
    it.req_type = rtcr_pkg::REQ_RECORD;
    it.rx_channel = ch[rtcr_pkg::CHANNEL_W-1:0];
    it.rx_rssi = rssi[rtcr_pkg::RSSI_W-1:0];
    it.kept = keep;
    it.expected_rssi = rtcr_pkg::RSSI_W'($urandom_range(255));
    return it;
  endfunction

  function automatic req_item_t make_pop(input int want);
    req_item_t it;
    it.req_type = rtcr_pkg::REQ_POP;
    it.rx_channel = rtcr_pkg::CHANNEL_W'($urandom_range(63));
    it.rx_rssi = rtcr_pkg::RSSI_W'($urandom_range(255));
    it.kept = 1'($urandom_range(1));
    it.expected_rssi = want[rtcr_pkg::RSSI_W-1:0];
    return it;
  endfunction

  // small set of rssi values so pops find matches often
  function automatic int common_rssi();
    case ($urandom_range(9))
      0: return -128;
      1: return 127;
      2: return 0;
      default: return -30 - 4 * int'($urandom_range(6));
    endcase
  endfunction

  task automatic send_req(input req_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.req_type <= it.req_type;
    req_ch.rx_channel <= it.rx_channel;
    req_ch.rx_rssi <= it.rx_rssi;
    req_ch.kept <= it.kept;
    req_ch.expected_rssi <= it.expected_rssi;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    apply_to_ring_model(it);
    if (it.req_type == rtcr_pkg::REQ_RECORD && it.kept) last_rssi = it.rx_rssi;
  endtask

  task automatic report_mismatch(input string what, input pop_result_t want);
    mismatches++;
    if (mismatches <= 10) begin
      $write("%0t: %s: expected ch %0d matched %0d discards %0d, ",
             $realtime, what, want.channel, want.matched, want.discards);
      $display("got ch %0d matched %0d discards %0d",
               rsp_ch.channel_out, rsp_ch.matched, rsp_ch.discard_count);
    end
  endtask

  task automatic test_pop_before_record();
    send_req(make_pop(0));
    send_req(make_pop(-128));
  endtask

  task automatic test_zero_entries();
    // a discarded record sets the seen flag, never-written entries match rssi 0
    send_req(make_record(63, -128, 1'b0));
    send_req(make_pop(0));
  endtask

  task automatic test_field_extremes();
    send_req(make_record(39, 127, 1'b1));
    send_req(make_record(63, -128, 1'b1));
    send_req(make_record(0, -1, 1'b1));
    send_req(make_record(42, 1, 1'b1));
    send_req(make_record(21, 85, 1'b0));
    send_req(make_pop(127));
    send_req(make_pop(-128));
    send_req(make_pop(-1));
    send_req(make_pop(1));
    send_req(make_pop(55));
    send_req(make_pop(-86));
  endtask

  task automatic test_ring_wrap();
    for (int i = 0; i < DEPTH + 6; i++) begin
      send_req(make_record(i % 64, i - 35, 1'b1));
    end
    send_req(make_pop(2 - 35));
    send_req(make_pop(DEPTH + 4 - 35));
    send_req(make_pop(10 - 35));
    send_req(make_pop(100));
  endtask

  task automatic test_backpressure();
    hold_off = 300;
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 2) send_req(make_pop(common_rssi()));
      else send_req(make_record($urandom_range(39), common_rssi(), 1'b1));
    end
  endtask

  task automatic test_discard_count();
    for (int i = 0; i < 150; i++) begin
      send_req(make_record($urandom_range(39), $urandom_range(255), 1'b0));
    end
    send_req(make_pop(common_rssi()));
    send_req(make_pop(common_rssi()));
  endtask

  task automatic run_random(input int count);
    int pick;
    int ch;
    int rssi;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 62) begin
        ch = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(39);
        rssi = ($urandom_range(1) == 0) ? common_rssi() : int'($urandom_range(255));
        send_req(make_record(ch, rssi, $urandom_range(99) < 85));
      end else begin
        pick = $urandom_range(9);
        if (pick < 6) send_req(make_pop(common_rssi()));
        else if (pick < 8) send_req(make_pop(last_rssi));
        else send_req(make_pop($urandom_range(255)));
      end
    end
  endtask

  // result side, with optional long hold-off
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        hold_off--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pop_results_due.size() == 0) begin
        report_mismatch("result with no pop pending", '0);
      end else if (rsp_ch.channel_out !== pop_results_due[0].channel
                   || rsp_ch.matched !== pop_results_due[0].matched
                   || rsp_ch.discard_count !== pop_results_due[0].discards) begin
        report_mismatch("pop result mismatch", pop_results_due.pop_front());
      end else begin
        void'(pop_results_due.pop_front());
      end
    end
  end

  initial begin
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = rtcr_pkg::REQ_RECORD;
    req_ch.rx_channel = '0;
    req_ch.rx_rssi = '0;
    req_ch.kept = 1'b0;
    req_ch.expected_rssi = '0;
    hold_off = 0;
    mismatches = 0;
    last_rssi = '0;
    send_idle_pct = 26;
    recv_idle_pct = 46;
    clear_ring_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_pop_before_record();
    test_zero_entries();
    test_field_extremes();
    test_ring_wrap();
    run_random(260);

    send_idle_pct = 46;
    recv_idle_pct = 26;
    test_backpressure();
    run_random(260);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_discard_count();
    run_random(260);

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pop_results_due.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    mismatches += pop_results_due.size();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+sv
sv/rtcr_pkg.sv
sv/rtcr_chan_if.sv
sv/rtcr_ram.sv
sv/rssi_tagged_channel_ring.sv
sim/testbench.sv
